>>> src/arpr_pkg.sv
// ---------------------------------------------------------------------------
// ARP proxy responder package
// Shared constants, state encoding and inter-module structures.
// ---------------------------------------------------------------------------
package arpr_pkg;

   // Default depth of the host table.
   localparam int unsigned MAX_HOSTS_DEF = 512;

   // Frame geometry: every request is judged on, and every reply has, 42 bytes.
   localparam int unsigned POS_W     = 6;
   localparam logic [POS_W-1:0] FRAME_LEN = 6'd42;
   localparam logic [POS_W-1:0] LAST_POS  = 6'd41;

   // Byte offsets inside an Ethernet frame carrying ARP.
   localparam logic [POS_W-1:0] OFS_ETHERTYPE = 6'd12;
   localparam logic [POS_W-1:0] OFS_OPCODE    = 6'd20;
   localparam logic [POS_W-1:0] OFS_SHA       = 6'd22;
   localparam logic [POS_W-1:0] OFS_SPA       = 6'd28;
   localparam logic [POS_W-1:0] OFS_THA       = 6'd32;
   localparam logic [POS_W-1:0] OFS_TPA       = 6'd38;

   // Input beat selector codes.
   localparam logic [1:0] OP_FRAME_BYTE = 2'd0;
   localparam logic [1:0] OP_ADD_HOST   = 2'd1;
   localparam logic [1:0] OP_CLEAR      = 2'd2;

   // Protocol field values.
   localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
   localparam logic [15:0] OPCODE_REQUEST = 16'h0001;
   localparam logic [15:0] OPCODE_REPLY   = 16'h0002;
   localparam logic [7:0]  HLEN_ETHERNET  = 8'd6;
   localparam logic [7:0]  PLEN_IPV4      = 8'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_REPLY
   } state_type;

   // Fields picked out of the received frame.
   typedef struct packed {
      logic        qualified;
      logic [47:0] sha;
      logic [31:0] spa;
      logic [31:0] tpa;
   } frame_info_type;

   // Result of a table walk.
   typedef struct packed {
      logic        done;
      logic        hit;
      logic [47:0] mac;
   } lookup_status_type;

endpackage

>>> src/arpr_if.sv
// ---------------------------------------------------------------------------
// ARP proxy responder channels
// Valid/ready interfaces for the request and the reply streams.
// ---------------------------------------------------------------------------
interface arpr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [7:0]  frame_byte;
   logic        frame_end;
   logic [31:0] host_ip;
   logic [47:0] host_mac;

   modport source (output valid, op, frame_byte, frame_end, host_ip, host_mac,
                   input ready);
   modport sink (input valid, op, frame_byte, frame_end, host_ip, host_mac,
                 output ready);
endinterface

interface arpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_byte;
   logic       reply_last;

   modport source (output valid, reply_byte, reply_last, input ready);
   modport sink (input valid, reply_byte, reply_last, output ready);
endinterface

>>> src/arpr_capture.sv
// ---------------------------------------------------------------------------
// ARP proxy responder frame capture
// Counts the bytes of a frame and keeps the fields that the reply needs.
// ---------------------------------------------------------------------------
module arpr_capture (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_en,
   input  logic [7:0]              frame_byte,
   input  logic                    frame_clear,
   output arpr_pkg::frame_info_type info
);
   import arpr_pkg::*;

   logic [POS_W-1:0] count_ff, count_in;
   logic [15:0]      ethertype_ff, ethertype_in;
   logic [15:0]      opcode_ff, opcode_in;
   logic [47:0]      sha_ff, sha_in;
   logic [31:0]      spa_ff, spa_in;
   logic [31:0]      tpa_ff, tpa_in;

   // Bytes arrive in wire order, so each field is a shift register that takes
   // a byte while the count sits inside its span.
   always_comb begin
      count_in     = count_ff;
      ethertype_in = ethertype_ff;
      opcode_in    = opcode_ff;
      sha_in       = sha_ff;
      spa_in       = spa_ff;
      tpa_in       = tpa_ff;
      if (frame_clear) begin
         count_in = '0;
      end else if (byte_en && (count_ff < FRAME_LEN)) begin
         count_in = count_ff + 6'd1;
         if ((count_ff == OFS_ETHERTYPE) || (count_ff == OFS_ETHERTYPE + 6'd1)) begin
            ethertype_in = {ethertype_ff[7:0], frame_byte};
         end
         if ((count_ff == OFS_OPCODE) || (count_ff == OFS_OPCODE + 6'd1)) begin
            opcode_in = {opcode_ff[7:0], frame_byte};
         end
         if ((count_ff >= OFS_SHA) && (count_ff < OFS_SPA)) begin
            sha_in = {sha_ff[39:0], frame_byte};
         end
         if ((count_ff >= OFS_SPA) && (count_ff < OFS_THA)) begin
            spa_in = {spa_ff[23:0], frame_byte};
         end
         if (count_ff >= OFS_TPA) begin
            tpa_in = {tpa_ff[23:0], frame_byte};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ethertype_ff <= ethertype_in;
      opcode_ff    <= opcode_in;
      sha_ff       <= sha_in;
      spa_ff       <= spa_in;
      tpa_ff       <= tpa_in;
   end

   assign info.qualified = (count_ff == FRAME_LEN) && (ethertype_ff == ETHERTYPE_ARP) &&
                           (opcode_ff == OPCODE_REQUEST);
   assign info.sha = sha_ff;
   assign info.spa = spa_ff;
   assign info.tpa = tpa_ff;

endmodule

>>> src/arpr_table.sv
// ---------------------------------------------------------------------------
// ARP proxy responder host table
// IP and MAC memories with append, clear and a linear first-match walk.
// ---------------------------------------------------------------------------
module arpr_table #(
   parameter int unsigned MAX_HOSTS = arpr_pkg::MAX_HOSTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       add_en,
   input  logic [31:0]                host_ip,
   input  logic [47:0]                host_mac,
   input  logic                       clear_en,
   input  logic                       search_start,
   input  logic [31:0]                want_ip,
   output arpr_pkg::lookup_status_type status
);
   import arpr_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_HOSTS + 1);
   localparam int unsigned IDX_W = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
   localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_HOSTS);

   logic [31:0] ip_mem  [MAX_HOSTS];
   logic [47:0] mac_mem [MAX_HOSTS];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic             active_ff, active_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [31:0]      rd_ip_ff;
   logic [47:0]      rd_mac_ff;
   logic             write_en;
   logic             issue;
   logic             hit;
   logic             done;

   assign write_en = add_en && (count_ff < CAPACITY);

   // One read is issued per cycle; its data is registered and compared in the next cycle.
   assign hit   = active_ff && cmp_vld_ff && (rd_ip_ff == want_ip);
   assign done  = active_ff && (hit || (addr_ff == count_ff));
   assign issue = active_ff && !hit && (addr_ff != count_ff);

   always_comb begin
      count_in = count_ff;
      if (clear_en) begin
         count_in = '0;
      end else if (write_en) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      active_in  = active_ff;
      addr_in    = addr_ff;
      cmp_vld_in = issue;
      if (search_start) begin
         active_in  = 1'b1;
         addr_in    = '0;
         cmp_vld_in = 1'b0;
      end else begin
         if (done) begin
            active_in = 1'b0;
         end
         if (issue) begin
            addr_in = addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         addr_ff    <= '0;
         active_ff  <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         addr_ff    <= addr_in;
         active_ff  <= active_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         ip_mem[count_ff[IDX_W-1:0]]  <= host_ip;
         mac_mem[count_ff[IDX_W-1:0]] <= host_mac;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ip_ff  <= ip_mem[addr_ff[IDX_W-1:0]];
         rd_mac_ff <= mac_mem[addr_ff[IDX_W-1:0]];
      end
   end

   assign status.done = done;
   assign status.hit  = hit;
   assign status.mac  = rd_mac_ff;

endmodule

>>> src/arpr_reply.sv
// ---------------------------------------------------------------------------
// ARP proxy responder reply generator
// Builds the 42-byte reply and drives it out through an output register.
// ---------------------------------------------------------------------------
module arpr_reply (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [47:0]              entry_mac,
   input  arpr_pkg::frame_info_type info,
   output logic                     done,
   arpr_rsp_if.source               rsp_ch
);
   import arpr_pkg::*;

   logic [47:0]      mac_ff, mac_in;
   logic             active_ff, active_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             load;
   logic [POS_W-1:0] sel;
   logic [8*42-1:0]  frame_vec;

   // Whole reply, first wire byte in the top bits.
   assign frame_vec = {info.sha, mac_ff, ETHERTYPE_ARP, HTYPE_ETHERNET, ETHERTYPE_IPV4,
                       HLEN_ETHERNET, PLEN_IPV4, OPCODE_REPLY, mac_ff, info.tpa,
                       info.sha, info.spa};
   assign sel  = LAST_POS - pos_ff;
   assign load = active_ff && (!valid_ff || rsp_ch.ready);

   always_comb begin
      mac_in    = mac_ff;
      active_in = active_ff;
      pos_in    = pos_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      if (start) begin
         mac_in    = entry_mac;
         active_in = 1'b1;
         pos_in    = '0;
      end else if (load) begin
         byte_in  = frame_vec[{sel, 3'b000} +: 8];
         last_in  = (pos_ff == LAST_POS);
         valid_in = 1'b1;
         pos_in   = pos_ff + 6'd1;
         if (pos_ff == LAST_POS) begin
            active_in = 1'b0;
         end
      end else if (valid_ff && rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         pos_ff    <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff  <= mac_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign done              = valid_ff && rsp_ch.ready && last_ff;
   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.reply_byte = byte_ff;
   assign rsp_ch.reply_last = last_ff;

endmodule

>>> src/arp_proxy_responder.sv
// ---------------------------------------------------------------------------
// ARP proxy responder
// Answers ARP requests for the IPv4 addresses held in a host table.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Beat carries
//   req_ch    in         op, frame_byte, frame_end, host_ip, host_mac
//   rsp_ch    out        reply_byte, reply_last (one beat per reply byte)
//
// Frame bytes, adds and clears are taken while idle, and beats other than a
// frame end may follow back to back. A frame end leads to the check state,
// then, for a qualifying request, a walk of the table memory at one entry per
// cycle through a registered read port, then, on a hit, the load of the reply
// output register and 42 reply beats; the input is held off for all of that.
// Reset clears the counters and control only: the host
// memories start undefined, as the entry count keeps unwritten entries out
// of reach, so there is no clearing pass. Stalls on the reply side simply
// hold the reply byte in its output register.
//
module arp_proxy_responder #(
   parameter int unsigned MAX_HOSTS = arpr_pkg::MAX_HOSTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   arpr_req_if.sink   req_ch,
   arpr_rsp_if.source rsp_ch
);
   import arpr_pkg::*;

   state_type         state_ff, state_in;
   logic              beat;
   logic              byte_en;
   logic              add_en;
   logic              clear_en;
   logic              frame_clear;
   logic              search_start;
   logic              reply_start;
   logic              reply_done;
   frame_info_type    info;
   lookup_status_type status;

   // Beats are taken only while idle, so the capture fields and the table
   // stay still during a lookup and a reply.
   assign beat     = req_ch.valid && req_ch.ready;
   assign byte_en  = beat && (req_ch.op == OP_FRAME_BYTE);
   assign add_en   = beat && (req_ch.op == OP_ADD_HOST);
   assign clear_en = beat && (req_ch.op == OP_CLEAR);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (byte_en && req_ch.frame_end) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = info.qualified ? ST_SEARCH : ST_IDLE;
         end
         ST_SEARCH: begin
            if (status.done) begin
               state_in = status.hit ? ST_REPLY : ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (reply_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the controller. The check cycle also ends the frame, so the
   // byte count starts over whether or not a reply follows.
   always_comb begin
      req_ch.ready = 1'b0;
      frame_clear  = 1'b0;
      search_start = 1'b0;
      reply_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_CHECK: begin
            frame_clear  = 1'b1;
            search_start = info.qualified;
         end
         ST_SEARCH: begin
            reply_start = status.done && status.hit;
         end
         ST_REPLY: begin
            req_ch.ready = 1'b0;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   arpr_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .byte_en     (byte_en),
      .frame_byte  (req_ch.frame_byte),
      .frame_clear (frame_clear),
      .info        (info)
   );

   // The walk runs from the lowest index, so the first match wins when the
   // same address was added more than once.
   arpr_table #(
      .MAX_HOSTS (MAX_HOSTS)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .add_en       (add_en),
      .host_ip      (req_ch.host_ip),
      .host_mac     (req_ch.host_mac),
      .clear_en     (clear_en),
      .search_start (search_start),
      .want_ip      (info.tpa),
      .status       (status)
   );

   arpr_reply u_reply (
      .clock     (clock),
      .reset     (reset),
      .start     (reply_start),
      .entry_mac (status.mac),
      .info      (info),
      .done      (reply_done),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> src/arpr_checker.sv
// ---------------------------------------------------------------------------
// ARP proxy responder checker
// Port-level properties of the responder, bound to the top level.
// ---------------------------------------------------------------------------
module arpr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_op,
   input logic       req_frame_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_reply_byte,
   input logic       rsp_reply_last
);
   import arpr_pkg::*;

   logic req_beat;
   logic frame_end_beat;

   assign req_beat       = req_valid && req_ready;
   assign frame_end_beat = req_beat && (req_op == OP_FRAME_BYTE) && req_frame_end;

   // A reply is never in flight while requests are being taken.
   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("reply beat offered while the request side is open");

   // A frame end closes the request side for at least the check cycle.
   a_frame_end_stall : assert property (@(posedge clock) disable iff (reset)
      frame_end_beat |=> !req_ready)
      else $error("request side still open after a frame end");

   // Any other beat leaves the block ready for the next one.
   a_plain_beat_ready : assert property (@(posedge clock) disable iff (reset)
      (req_beat && !frame_end_beat) |=> req_ready)
      else $error("request side closed after a beat that is not a frame end");

   // Nothing follows the last reply beat without a new request.
   a_last_ends_reply : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_reply_last) |=> !rsp_valid)
      else $error("reply beat offered right after the last one");

   // A stalled reply beat holds.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_reply_byte) && $stable(rsp_reply_last)))
      else $error("stalled reply beat changed");

endmodule

bind arp_proxy_responder arpr_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_op         (req_ch.op),
   .req_frame_end  (req_ch.frame_end),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_reply_byte (rsp_ch.reply_byte),
   .rsp_reply_last (rsp_ch.reply_last)
);

>>> tb/arp_proxy_responder_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ARP proxy responder testbench
// Drives frame bytes, host adds, clears and ignored beats into the request
// channel, predicts every reply byte from a behavioral copy of the host table
// and capture buffer, and checks the reply stream beat by beat. A short
// scripted section covers the corner cases, then the host table is filled
// past its limit, then a long randomized section runs with stalls on both
// channels, which are switched off for the last stretch.
// ---------------------------------------------------------------------------
module arp_proxy_responder_test;
   import arpr_pkg::*;

   localparam int HOST_LIMIT    = int'(MAX_HOSTS_DEF);
   localparam int FRAME_BYTES   = int'(FRAME_LEN);
   localparam int RANDOM_BEATS  = 430;
   localparam int TAIL_BEATS    = 80;
   // Check cycle, a walk of a full table and a whole reply, with margin.
   localparam int DRAIN_CYCLES  = 700;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRINT_LIMIT   = 40;
   localparam int MID_POS       = 20;

   // The selector code the block leaves unused.
   localparam logic [1:0] OP_IGNORED = 2'd3;

   localparam logic [31:0] IP_A  = 32'hC0A8_0107;
   localparam logic [31:0] IP_B  = 32'h0A00_00FE;
   localparam logic [47:0] MAC_1 = 48'h02_11_22_33_44_55;
   localparam logic [47:0] MAC_2 = 48'h02_66_77_88_99_AA;
   localparam logic [47:0] MAC_3 = 48'h06_DE_AD_01_02_03;

   typedef enum logic [1:0] {
      ROW_FRAME,
      ROW_ADD,
      ROW_CLEAR,
      ROW_IGNORED
   } row_kind_type;

   // One scripted step: a whole frame or a single beat, with the outcome that
   // can be read straight off the table contents at that point.
   typedef struct packed {
      row_kind_type kind;
      logic [6:0]   len;
      logic [15:0]  etype;
      logic [15:0]  opcode;
      logic [31:0]  ip;
      logic [47:0]  mac;
      logic [1:0]   mid_op;
      logic         want_reply;
      logic [47:0]  want_mac;
   } script_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } reply_beat_type;

   localparam int DIRECTED_ROWS = 22;

   script_row_type directed_rows [DIRECTED_ROWS] = '{
      // Empty table right after reset: nothing can answer.
      '{ROW_FRAME, 7'd42, ETHERTYPE_ARP, OPCODE_REQUEST, IP_A, '0, OP_IGNORED, 1'b0, '0},
      '{ROW_ADD, '0, '0, '0, IP_A, MAC_1, OP_IGNORED, 1'b0, '0},
      '{ROW_ADD, '0, '0, '0, IP_A, MAC_2, OP_IGNORED, 1'b0, '0},
      '{ROW_ADD, '0, '0, '0, '1, '1, OP_IGNORED, 1'b0, '0},
      '{ROW_ADD, '0, '0, '0, '0, '0, OP_IGNORED, 1'b0, '0},
      // Duplicate address: the lower entry wins.
      '{ROW_FRAME, 7'd42, ETHERTYPE_ARP, OPCODE_REQUEST, IP_A, '0, OP_IGNORED, 1'b1, MAC_1},
      '{ROW_FRAME, 7'd42, ETHERTYPE_ARP, OPCODE_REQUEST, '1, '0, OP_IGNORED, 1'b1, '1},
      '{ROW_FRAME, 7'd42, ETHERTYPE_ARP, OPCODE_REQUEST, '0, '0, OP_IGNORED, 1'b1, '0},
      // Wrong EtherType in either byte, wrong opcode in either byte.
      '{ROW_FRAME, 7'd42, ETHERTYPE_IPV4, OPCODE_REQUEST, IP_A, '0, OP_IGNORED, 1'b0, '0},
      '{ROW_FRAME, 7'd42, 16'h8806, OPCODE_REQUEST, IP_A, '0, OP_IGNORED, 1'b0, '0},
      '{ROW_FRAME, 7'd42, ETHERTYPE_ARP, OPCODE_REPLY, IP_A, '0, OP_IGNORED, 1'b0, '0},
      '{ROW_FRAME, 7'd42, ETHERTYPE_ARP, 16'h0101, IP_A, '0, OP_IGNORED, 1'b0, '0},
      // Short frames never answer; a long one is judged on its first 42 bytes.
      '{ROW_FRAME, 7'd41, ETHERTYPE_ARP, OPCODE_REQUEST, IP_A, '0, OP_IGNORED, 1'b0, '0},
      '{ROW_FRAME, 7'd1, ETHERTYPE_ARP, OPCODE_REQUEST, IP_A, '0, OP_IGNORED, 1'b0, '0},
      '{ROW_FRAME, 7'd70, ETHERTYPE_ARP, OPCODE_REQUEST, IP_A, '0, OP_IGNORED, 1'b1, MAC_1},
      // An add or a clear in the middle of a frame takes effect before its end.
      '{ROW_FRAME, 7'd42, ETHERTYPE_ARP, OPCODE_REQUEST, IP_B, MAC_3, OP_ADD_HOST, 1'b1, MAC_3},
      '{ROW_FRAME, 7'd42, ETHERTYPE_ARP, OPCODE_REQUEST, IP_A, '0, OP_CLEAR, 1'b0, '0},
      '{ROW_IGNORED, '0, '0, '0, '0, '0, OP_IGNORED, 1'b0, '0},
      '{ROW_FRAME, 7'd42, ETHERTYPE_ARP, OPCODE_REQUEST, IP_B, '0, OP_IGNORED, 1'b0, '0},
      // After a clear, only the newly appended entry is visible.
      '{ROW_ADD, '0, '0, '0, IP_A, MAC_2, OP_IGNORED, 1'b0, '0},
      '{ROW_FRAME, 7'd42, ETHERTYPE_ARP, OPCODE_REQUEST, IP_A, '0, OP_IGNORED, 1'b1, MAC_2},
      '{ROW_CLEAR, '0, '0, '0, '0, '0, OP_IGNORED, 1'b0, '0}
   };

   logic clock;
   logic reset;

   arpr_req_if req_ch ();
   arpr_rsp_if rsp_ch ();

   arp_proxy_responder #(
      .MAX_HOSTS (HOST_LIMIT)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Behavioral copy of the block's state.
   logic [0:FRAME_BYTES-1][7:0] capture;
   int                          captured;
   logic [31:0]                 host_ip_tbl [HOST_LIMIT];
   logic [47:0]                 host_mac_tbl [HOST_LIMIT];
   int                          host_count;

   reply_beat_type reply_due [$];
   reply_beat_type head_beat;
   int             replies_predicted;
   logic [47:0]    last_reply_mac;
   int             fail_count;
   int             beats_sent;
   int             cycle_count;
   int             req_gap_pct;
   int             rsp_stall_pct;
   int             stall_left;

   initial begin
      clock = 1'b0;
   end

   always begin
      #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("[%0t] MISMATCH: %s", $time, what);
      end
   endtask

   function automatic logic [47:0] random_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Applies one accepted request beat to the state copy and queues the reply
   // bytes that it causes.
   function automatic void predict_reply(input logic [1:0] op, input logic [7:0] fbyte,
                                         input logic fend, input logic [31:0] ip,
                                         input logic [47:0] mac);
      logic                        hit;
      logic [47:0]                 found_mac;
      logic [0:FRAME_BYTES-1][7:0] reply;
      int                          idx;

      hit = 1'b0;
      found_mac = '0;
      case (op)
         OP_FRAME_BYTE: begin
            if (captured < FRAME_BYTES) begin
               capture[captured] = fbyte;
               captured++;
            end
            if (fend) begin
               if (captured == FRAME_BYTES &&
                   capture[OFS_ETHERTYPE +: 2] == ETHERTYPE_ARP &&
                   capture[OFS_OPCODE +: 2] == OPCODE_REQUEST) begin
                  for (idx = 0; idx < host_count && !hit; idx++) begin
                     if (host_ip_tbl[idx] == capture[OFS_TPA +: 4]) begin
                        hit = 1'b1;
                        found_mac = host_mac_tbl[idx];
                     end
                  end
               end
               if (hit) begin
                  reply = {capture[OFS_SHA +: 6], found_mac, ETHERTYPE_ARP, HTYPE_ETHERNET,
                           ETHERTYPE_IPV4, HLEN_ETHERNET, PLEN_IPV4, OPCODE_REPLY,
                           found_mac, capture[OFS_TPA +: 4], capture[OFS_SHA +: 6],
                           capture[OFS_SPA +: 4]};
                  for (idx = 0; idx < FRAME_BYTES; idx++) begin
                     reply_due.push_back('{reply[idx], idx == FRAME_BYTES - 1});
                  end
                  replies_predicted++;
                  last_reply_mac = found_mac;
               end
               captured = 0;
            end
         end
         OP_ADD_HOST: begin
            if (host_count < HOST_LIMIT) begin
               host_ip_tbl[host_count] = ip;
               host_mac_tbl[host_count] = mac;
               host_count++;
            end
         end
         OP_CLEAR: begin
            host_count = 0;
         end
         default: begin
         end
      endcase
   endfunction

   // Reply checking comes first: a reply never leaves in the cycle its
   // request beat is accepted, so the order within this block is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (reply_due.size() == 0) begin
               report_mismatch($sformatf("reply byte %02h with no reply outstanding",
                                         rsp_ch.reply_byte));
            end else begin
               head_beat = reply_due.pop_front();
               if (rsp_ch.reply_byte !== head_beat.data) begin
                  report_mismatch($sformatf("reply_byte %02h, expected %02h",
                                            rsp_ch.reply_byte, head_beat.data));
               end
               if (rsp_ch.reply_last !== head_beat.last) begin
                  report_mismatch($sformatf("reply_last %0b, expected %0b",
                                            rsp_ch.reply_last, head_beat.last));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_reply(req_ch.op, req_ch.frame_byte, req_ch.frame_end, req_ch.host_ip,
                          req_ch.host_mac);
         end
      end
   end

   // Reply-side backpressure: stall bursts of random length.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_ch.ready = 1'b0;
         stall_left = $urandom_range(0, 14);
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   // Sends one request beat, entered and left at a falling edge. An idle
   // burst may come first; valid then stays high until the beat is taken.
   task automatic send_beat(input logic [1:0] op, input logic [7:0] fbyte,
                            input logic fend, input logic [31:0] ip,
                            input logic [47:0] mac);
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_ch.op = op;
      req_ch.frame_byte = fbyte;
      req_ch.frame_end = fend;
      req_ch.host_ip = ip;
      req_ch.host_mac = mac;
      req_ch.valid = 1'b1;
      do begin
         @(posedge clock);
      end while (req_ch.ready !== 1'b1);
      @(negedge clock);
      beats_sent++;
   endtask

   // Sends an ARP-shaped frame of len bytes; bytes past the 42nd are random.
   // One extra beat of kind mid_op goes in ahead of byte mid_pos, if any.
   task automatic send_frame(input int len, input logic [15:0] etype,
                             input logic [15:0] opcode, input logic [31:0] tpa,
                             input int mid_pos, input logic [1:0] mid_op,
                             input logic [31:0] mid_ip, input logic [47:0] mid_mac);
      logic [0:FRAME_BYTES-1][7:0] pkt;
      logic [47:0]                 dst;
      int                          pos;

      dst = $urandom_range(0, 1) ? '1 : random_mac();
      pkt = {dst, random_mac(), etype, HTYPE_ETHERNET, ETHERTYPE_IPV4, HLEN_ETHERNET,
             PLEN_IPV4, opcode, random_mac(), 32'($urandom), random_mac(), tpa};
      for (pos = 0; pos < len; pos++) begin
         if (pos == mid_pos) begin
            send_beat(mid_op, 8'($urandom), 1'($urandom), mid_ip, mid_mac);
         end
         send_beat(OP_FRAME_BYTE, pos < FRAME_BYTES ? pkt[pos] : 8'($urandom),
                   pos == len - 1, 32'($urandom), random_mac());
      end
   endtask

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      script_row_type cur;
      int             row;
      int             seen;
      int             k;
      int             choice;
      int             len;
      int             random_start;
      logic [15:0]    etype;
      logic [15:0]    opcode;
      logic [31:0]    tpa;
      logic [31:0]    spare_ip;

      cycle_count = 0;
      fail_count = 0;
      beats_sent = 0;
      replies_predicted = 0;
      last_reply_mac = '0;
      captured = 0;
      host_count = 0;
      stall_left = 0;
      req_gap_pct = 20;
      rsp_stall_pct = 20;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = OP_IGNORED;
      req_ch.frame_byte = '0;
      req_ch.frame_end = 1'b0;
      req_ch.host_ip = '0;
      req_ch.host_mac = '0;
      rsp_ch.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Scripted corner cases. The hand-written outcome of each row is held
      // against the prediction; the reply bytes themselves are checked by
      // the monitor like every other beat.
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         cur = directed_rows[row];
         seen = replies_predicted;
         case (cur.kind)
            ROW_FRAME: begin
               send_frame(int'(cur.len), cur.etype, cur.opcode, cur.ip, MID_POS, cur.mid_op,
                          cur.ip, cur.mac);
            end
            ROW_ADD: begin
               send_beat(OP_ADD_HOST, 8'($urandom), 1'($urandom), cur.ip, cur.mac);
            end
            ROW_CLEAR: begin
               send_beat(OP_CLEAR, 8'($urandom), 1'($urandom), 32'($urandom), random_mac());
            end
            default: begin
               send_beat(OP_IGNORED, 8'($urandom), 1'($urandom), 32'($urandom),
                         random_mac());
            end
         endcase
         if ((replies_predicted != seen) !== cur.want_reply) begin
            report_mismatch($sformatf("script row %0d: reply expected %0b", row,
                                      cur.want_reply));
         end else if (cur.want_reply && last_reply_mac !== cur.want_mac) begin
            report_mismatch($sformatf("script row %0d: reply MAC %012h, expected %012h",
                                      row, last_reply_mac, cur.want_mac));
         end
      end

      // Fill the host table, push two adds past its end, then look up the
      // first entry, the last entry (longest walk) and a dropped address.
      send_beat(OP_CLEAR, 8'($urandom), 1'($urandom), 32'($urandom), random_mac());
      for (k = 0; k < HOST_LIMIT; k++) begin
         send_beat(OP_ADD_HOST, 8'($urandom), 1'($urandom), 32'($urandom), random_mac());
      end
      spare_ip = 32'($urandom);
      send_beat(OP_ADD_HOST, 8'($urandom), 1'($urandom), spare_ip, random_mac());
      send_beat(OP_ADD_HOST, 8'($urandom), 1'($urandom), 32'($urandom), random_mac());
      send_frame(FRAME_BYTES, ETHERTYPE_ARP, OPCODE_REQUEST, host_ip_tbl[0], -1,
                 OP_IGNORED, '0, '0);
      send_frame(FRAME_BYTES, ETHERTYPE_ARP, OPCODE_REQUEST, host_ip_tbl[HOST_LIMIT - 1],
                 -1, OP_IGNORED, '0, '0);
      send_frame(FRAME_BYTES, ETHERTYPE_ARP, OPCODE_REQUEST, spare_ip, -1, OP_IGNORED,
                 '0, '0);
      send_beat(OP_CLEAR, 8'($urandom), 1'($urandom), 32'($urandom), random_mac());

      // Randomized traffic, mostly well-formed requests against a table that
      // grows by random adds, with broken frames and stray beats mixed in.
      random_start = beats_sent;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         if (beats_sent - random_start >= RANDOM_BEATS - TAIL_BEATS) begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: req_gap_pct = 0;
               1: req_gap_pct = 5;
               2: req_gap_pct = 20;
               default: req_gap_pct = 50;
            endcase
            case ($urandom_range(0, 3))
               0: rsp_stall_pct = 0;
               1: rsp_stall_pct = 5;
               2: rsp_stall_pct = 20;
               default: rsp_stall_pct = 50;
            endcase
         end
         if (host_count > 0 && $urandom_range(0, 3) != 0) begin
            tpa = host_ip_tbl[$urandom_range(0, host_count - 1)];
         end else begin
            tpa = 32'($urandom);
         end
         choice = $urandom_range(0, 99);
         if (choice < 50) begin
            send_frame(FRAME_BYTES, ETHERTYPE_ARP, OPCODE_REQUEST, tpa,
                       $urandom_range(0, 7) == 0 ? $urandom_range(0, FRAME_BYTES - 1) : -1,
                       2'($urandom), $urandom_range(0, 1) ? tpa : 32'($urandom),
                       random_mac());
         end else if (choice < 62) begin
            len = FRAME_BYTES;
            etype = ETHERTYPE_ARP;
            opcode = OPCODE_REQUEST;
            case ($urandom_range(0, 3))
               0: len = $urandom_range(1, FRAME_BYTES - 1);
               1: len = $urandom_range(FRAME_BYTES + 1, 80);
               2: etype = 16'($urandom);
               default: opcode = 16'($urandom);
            endcase
            send_frame(len, etype, opcode, tpa, -1, OP_IGNORED, '0, '0);
         end else if (choice < 84) begin
            send_beat(OP_ADD_HOST, 8'($urandom), 1'($urandom),
                      $urandom_range(0, 3) == 0 ? tpa : 32'($urandom), random_mac());
         end else if (choice < 88) begin
            send_beat(OP_CLEAR, 8'($urandom), 1'($urandom), 32'($urandom), random_mac());
         end else if (choice < 94) begin
            send_beat(OP_IGNORED, 8'($urandom), 1'($urandom), 32'($urandom), random_mac());
         end else begin
            // A stray byte knocks the next frame out of alignment.
            send_beat(OP_FRAME_BYTE, 8'($urandom), 1'($urandom), 32'($urandom),
                      random_mac());
         end
      end
      req_ch.valid = 1'b0;

      while (reply_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

>>> arp_proxy_responder.f
src/arpr_pkg.sv
src/arpr_if.sv
src/arpr_capture.sv
src/arpr_table.sv
src/arpr_reply.sv
src/arp_proxy_responder.sv
src/arpr_checker.sv
tb/arp_proxy_responder_test.sv
